[hw/rtl/rpnh_pkg.sv]
// rpnh_pkg: types, constants and controller/datapath command structs for
// ray_primitive_nearest_hit. No dependencies.
package rpnh_pkg;

    localparam int DW = 32;
    localparam int IW = 8;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               prim_kind;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] radius;
        logic               last_prim;
    } t_in_item;

    typedef struct packed {
        logic               hit_found;
        logic signed [31:0] hit_distance;
        logic        [7:0]  hit_index;
    } t_out_item;

    localparam logic [0:0] CFG_MIN_DIST = 1'b0;
    localparam logic [0:0] CFG_MAX_DIST = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_PROD, S_SUM, S_HH, S_DISC, S_SQRT,
        S_DIV1, S_DIV2S, S_DIV2, S_DIVP, S_PICK, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input beat
        logic do_diff;
        logic do_prod;     // one of seven products per cycle, sel below
        logic [2:0] prod_sel;
        logic do_sum;
        logic do_hh;       // h*h and a*c
        logic do_disc;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;   // start divider
        logic [1:0] div_sel; // 0: root1 1: root2 2: plane
        logic div_step;
        logic div_save;
        logic pick;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_plane;
        logic dy_zero;
        logic sph_miss;
        logic sqrt_done;
        logic div_done;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

[hw/rtl/rpnh_ctrl.sv]
// rpnh_ctrl: sequencer for one item; issues rpnh_pkg::t_cmd to the datapath.
// Depends on rpnh_pkg.
module rpnh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  rpnh_pkg::t_status i_st,
    output rpnh_pkg::t_cmd    o_cmd
);
    import rpnh_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;
    // input is taken only in S_IDLE; one item in flight at a time
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ov    = r_ov && i_out_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.do_diff = 1'b1;
                n_cnt = '0;
                if (i_st.is_plane) begin
                    if (i_st.dy_zero) n_state = S_PICK;
                    else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel = 2'd2;
                        n_state = S_DIVP;
                    end
                end else n_state = S_PROD;
            end
            S_PROD: begin
                o_cmd.do_prod = 1'b1;
                o_cmd.prod_sel = r_cnt;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd6) n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state = S_HH;
            end
            S_HH: begin
                o_cmd.do_hh = 1'b1;
                n_state = S_DISC;
            end
            S_DISC: begin
                o_cmd.do_disc = 1'b1;
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_st.sph_miss) n_state = S_PICK;
                else if (i_st.sqrt_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = 2'd0;
                    n_state = S_DIV1;
                end else o_cmd.sqrt_step = 1'b1;
            end
            S_DIV1: begin
                if (i_st.div_done) begin
                    o_cmd.div_save = 1'b1;
                    o_cmd.div_sel = 2'd0;
                    n_state = S_DIV2S;
                end else o_cmd.div_step = 1'b1;
            end
            S_DIV2S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel = 2'd1;
                n_state = S_DIV2;
            end
            S_DIV2, S_DIVP: begin
                o_cmd.div_sel = (r_state == S_DIV2) ? 2'd1 : 2'd2;
                if (i_st.div_done) begin
                    o_cmd.div_save = 1'b1;
                    n_state = S_PICK;
                end else o_cmd.div_step = 1'b1;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = i_last ? S_OUT : S_IDLE;
            end
            S_OUT: if (!(r_ov && i_out_stall)) begin
                o_cmd.emit = 1'b1;
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[hw/rtl/rpnh_dp.sv]
// rpnh_dp: arithmetic datapath (products, sqrt, restoring divider, best-hit
// tracking). Depends on rpnh_pkg.
module rpnh_dp #(
    parameter int MAX_PRIMS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpnh_pkg::t_in_item i_item,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  rpnh_pkg::t_cmd     i_cmd,
    output rpnh_pkg::t_status  o_st,
    output logic               o_last,
    output rpnh_pkg::t_out_item o_out
);
    import rpnh_pkg::*;

    localparam int CAPI = (MAX_PRIMS - 1 > 255) ? 255 : MAX_PRIMS - 1;
    localparam logic [7:0] IDX_CAP = 8'(CAPI);

    t_in_item r_it;
    logic signed [31:0] r_min, r_max;
    logic signed [31:0] r_dx, r_dy, r_dz;      // saturated diff
    logic signed [49:0] r_pa, r_ph, r_pc;      // accumulated floored products
    logic signed [31:0] r_a, r_h, r_c;
    logic signed [63:0] r_h2, r_ac;
    logic        [63:0] r_rem, r_res, r_bit;
    logic               r_miss;
    // divider: magnitude restoring, 1 bit/cycle over 64 bits of dividend
    logic        [63:0] r_dq;
    logic        [64:0] r_dr;
    logic        [31:0] r_dd;
    logic               r_dneg;
    logic        [6:0]  r_dcnt;
    logic signed [31:0] r_t1, r_t;
    logic               r_hit;
    logic signed [31:0] r_best;
    logic        [7:0]  r_bidx, r_cnt;
    logic               r_any;
    t_out_item          r_out;

    logic signed [32:0] max_p1;
    logic signed [31:0] nohit;
    assign max_p1 = {r_max[31], r_max} + 33'sd1;
    assign nohit  = sat32(66'(max_p1));

    // product operand select
    logic signed [31:0] pm_a, pm_b;
    logic signed [63:0] prod;
    logic signed [49:0] prod_f;
    always_comb begin
        pm_a = r_it.dir_x; pm_b = r_it.dir_x;
        unique case (i_cmd.prod_sel)
            3'd0: begin pm_a = r_it.dir_x; pm_b = r_it.dir_x; end
            3'd1: begin pm_a = r_it.dir_y; pm_b = r_it.dir_y; end
            3'd2: begin pm_a = r_it.dir_z; pm_b = r_it.dir_z; end
            3'd3: begin pm_a = r_dx; pm_b = r_it.dir_x; end
            3'd4: begin pm_a = r_dy; pm_b = r_it.dir_y; end
            3'd5: begin pm_a = r_dz; pm_b = r_it.dir_z; end
            3'd6: begin pm_a = r_dx; pm_b = r_dx; end
            default: begin pm_a = r_dx; pm_b = r_dx; end
        endcase
    end
    assign prod   = pm_a * pm_b;
    assign prod_f = 50'(prod >>> 16);

    // extra products for c: dy^2, dz^2, dx^2 on a second multiplier path; r^2 on its own
    logic signed [63:0] prod2;
    logic signed [31:0] pm_c;
    always_comb begin
        unique case (i_cmd.prod_sel)
            3'd3: pm_c = r_dy;
            3'd4: pm_c = r_dz;
            default: pm_c = r_dx;
        endcase
    end
    assign prod2 = pm_c * pm_c;
    logic [61:0] rr;
    assign rr = r_it.radius * r_it.radius;

    // isqrt step
    logic [63:0] sq_try;
    assign sq_try = r_res + r_bit;

    // divider dividend
    logic signed [63:0] num;
    logic signed [31:0] den;
    always_comb begin
        unique case (i_cmd.div_sel)
            2'd0: num = ((-64'(r_h)) - $signed(r_res)) <<< 16;
            2'd1: num = ((-64'(r_h)) + $signed(r_res)) <<< 16;
            default: num = (64'(r_it.center_y) - 64'(r_it.origin_y)) <<< 16;
        endcase
        den = (i_cmd.div_sel == 2'd2) ? r_it.dir_y : r_a;
    end
    logic [64:0] dsub;
    assign dsub = {r_dr[63:0], r_dq[63]} - {33'd0, r_dd};

    logic signed [64:0] qsig;
    assign qsig = r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    logic signed [31:0] qsat;
    assign qsat = sat32(66'(qsig));

    function automatic logic inr(input logic signed [31:0] t, input logic signed [31:0] lo,
                                 input logic signed [31:0] hi);
        return (lo <= t) && (t <= hi);
    endfunction

    logic signed [64:0] dsc;
    assign dsc = {r_h2[63], r_h2} - {r_ac[63], r_ac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= 32'sd655;
            r_max  <= 32'sh7FFFFFFF;
            r_best <= 32'sh7FFFFFFF;
            r_bidx <= '0;
            r_cnt  <= '0;
            r_any  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_DIST) r_min <= i_cfg_data;
                else r_max <= i_cfg_data;
            end
            if (i_cmd.pick) begin
                if (r_hit && (!r_any || r_t < r_best)) begin
                    r_best <= r_t;
                    r_bidx <= r_cnt;
                    r_any  <= 1'b1;
                end
                if (r_cnt < IDX_CAP) r_cnt <= r_cnt + 8'd1;
            end
            if (i_cmd.emit) begin
                r_any  <= 1'b0;
                r_bidx <= '0;
                r_cnt  <= '0;
                r_best <= nohit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_it <= i_item;
            r_pa <= '0; r_ph <= '0; r_pc <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.do_diff) begin
            r_dx <= sat32(66'(r_it.origin_x) - 66'(r_it.center_x));
            r_dy <= sat32(66'(r_it.origin_y) - 66'(r_it.center_y));
            r_dz <= sat32(66'(r_it.origin_z) - 66'(r_it.center_z));
            if (r_it.prim_kind && r_it.dir_y == 0) begin
                r_t   <= r_min;
                r_hit <= (r_it.center_y == r_it.origin_y) && inr(r_min, r_min, r_max);
            end
        end
        if (i_cmd.do_prod) begin
            unique case (i_cmd.prod_sel)
                3'd0, 3'd1, 3'd2: r_pa <= r_pa + prod_f;
                3'd3, 3'd4, 3'd5: begin
                    r_ph <= r_ph + prod_f;
                    r_pc <= r_pc + 50'(prod2 >>> 16);
                end
                default: r_pc <= r_pc - 50'({2'b0, rr} >> 16);
            endcase
        end
        if (i_cmd.do_sum) begin
            r_a <= sat32(66'(r_pa));
            r_h <= sat32(66'(r_ph));
            r_c <= sat32(66'(r_pc));
        end
        if (i_cmd.do_hh) begin
            r_h2 <= r_h * r_h;
            r_ac <= r_a * r_c;
        end
        if (i_cmd.do_disc) begin
            r_miss <= dsc[64] || (r_a == 0);
            r_rem  <= (dsc > 65'sh7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : dsc[63:0];
            r_res  <= '0;
            r_bit  <= 64'h4000000000000000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_rem >= sq_try) begin
                r_rem <= r_rem - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else r_res <= r_res >> 1;
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_save) begin
            if (i_cmd.div_sel == 2'd0) r_t1 <= qsat;
            else if (i_cmd.div_sel == 2'd1) begin
                priority if (inr(r_t1, r_min, r_max) && inr(qsat, r_min, r_max)) begin
                    r_t <= (r_t1 < qsat) ? r_t1 : qsat;
                    r_hit <= 1'b1;
                end else if (inr(r_t1, r_min, r_max)) begin
                    r_t <= r_t1; r_hit <= 1'b1;
                end else if (inr(qsat, r_min, r_max)) begin
                    r_t <= qsat; r_hit <= 1'b1;
                end else r_hit <= 1'b0;
            end else begin
                r_t   <= qsat;
                r_hit <= inr(qsat, r_min, r_max);
            end
        end
        if (i_cmd.div_start) begin
            r_dq   <= num[63] ? 64'(-num) : num;
            r_dd   <= den[31] ? 32'(-den) : den;
            r_dneg <= num[63] ^ den[31];
            r_dr   <= '0;
            r_dcnt <= 7'd64;
        end else if (i_cmd.div_step) begin
            if (!dsub[64]) r_dr <= dsub;
            else r_dr <= {r_dr[63:0], r_dq[63]};
            r_dq   <= {r_dq[62:0], ~dsub[64]};
            r_dcnt <= r_dcnt - 7'd1;
        end
        if (i_cmd.emit) begin
            r_out.hit_found    <= r_any;
            r_out.hit_distance <= r_any ? r_best : nohit;
            r_out.hit_index    <= r_any ? r_bidx : 8'd0;
        end
    end

    assign o_st.is_plane  = r_it.prim_kind;
    assign o_st.dy_zero   = (r_it.dir_y == 0);
    assign o_st.sph_miss  = r_miss;
    assign o_st.sqrt_done = (r_bit == 0);
    assign o_st.div_done  = (r_dcnt == 0);
    assign o_last = r_it.last_prim;
    assign o_out  = r_out;
endmodule

[hw/rtl/ray_primitive_nearest_hit.sv]
// ray_primitive_nearest_hit: nearest ray/sphere/plane hit over a run of items.
// Per item, accept to next accept: a sphere runs a 32-step sqrt and two 64-step
// divides, a plane one divide, a parallel plane or missed sphere neither; one at a time.
// A last item also passes S_OUT, waiting there while the previous result is stalled.
// Synchronous active-low reset clears controller, config and run state; datapath work regs are not reset.
module ray_primitive_nearest_hit #(
    parameter int MAX_PRIMS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rpnh_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rpnh_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import rpnh_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    last;

    rpnh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_last(last),
        .o_out_valid, .i_out_stall, .i_st(st), .o_cmd(cmd)
    );

    rpnh_dp #(.MAX_PRIMS(MAX_PRIMS)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_in_data), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_cmd(cmd), .o_st(st), .o_last(last), .o_out(o_out_data)
    );

    a_no_found_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit_found |-> o_out_data.hit_index == 8'd0)
        else $error("index set without hit");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !o_in_stall)
        else $error("load while busy");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> !cmd.emit)
        else $error("double emit");
endmodule
